// File: hdl/vector_angle_with_norms_macros.svh
// Assertion macros for the vector angle block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef VECTOR_ANGLE_WITH_NORMS_MACROS_SVH
`define VECTOR_ANGLE_WITH_NORMS_MACROS_SVH
`ifndef SYNTHESIS
`define VAWN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define VAWN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define VAWN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VAWN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/vawn_pkg.sv
// Shared types, constants and the arctangent table for the vector angle block.
// No dependencies.
`default_nettype none
package vawn_pkg;
	localparam int DEF_MAX_LEN = 1024;
	localparam int DOT_W = 42;
	localparam int SQ_W = 41;
	localparam int NORM_W = 21;
	localparam int RAD_W = 42;
	localparam int XY_W = 34;
	localparam int Z_W = 23;
	localparam logic [21:0] Z_HALF_PI = 22'd1647099;
	localparam logic [21:0] Z_PI = 22'd3294199;
	localparam logic [14:0] COS_ONE = 15'd16384;
	localparam logic [28:0] RAD_ONE = 29'h1000_0000;
	localparam logic [3:0] DIV_LAST = 4'd13;
	localparam logic [3:0] COR_LAST = 4'd15;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;

	localparam logic [1:0] SQ_SEL_A = 2'd0;
	localparam logic [1:0] SQ_SEL_B = 2'd1;
	localparam logic [1:0] SQ_SEL_C = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       clear;
		logic       sq_start;
		logic [1:0] sq_sel;
		logic       lat_na;
		logic       lat_nb;
		logic       lat_s;
		logic       mul;
		logic       div_init;
		logic       div_step;
		logic       sq_mag;
		logic       cor_init;
		logic       cor_step;
		logic [3:0] iter;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic sq_done;
		logic zero_norm;
		logic out_free;
	} sts_t;

	function automatic logic [19:0] atan_f(input logic [3:0] i);
		logic [19:0] v;
		case (i)
			4'd0: v = 20'd823550;
			4'd1: v = 20'd486170;
			4'd2: v = 20'd256879;
			4'd3: v = 20'd130396;
			4'd4: v = 20'd65451;
			4'd5: v = 20'd32757;
			4'd6: v = 20'd16383;
			4'd7: v = 20'd8192;
			4'd8: v = 20'd4096;
			4'd9: v = 20'd2048;
			4'd10: v = 20'd1024;
			4'd11: v = 20'd512;
			4'd12: v = 20'd256;
			4'd13: v = 20'd128;
			4'd14: v = 20'd64;
			4'd15: v = 20'd32;
			default: v = 20'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// File: hdl/vawn_sqrt.sv
// Bit-serial floor square root, one result bit per cycle.
// Depends on vawn_pkg.
`default_nettype none
module vawn_sqrt import vawn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAD_W-1:0]  radicand,
	output logic [NORM_W-1:0]      root,
	output logic                   done
);
	logic [RAD_W-1:0]  rad_q;
	logic [NORM_W+1:0] rem_q;
	logic [NORM_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NORM_W+3:0] nr;
	logic [NORM_W+3:0] trial;
	logic              take;

	assign nr = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign take = nr >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(NORM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q <= (NORM_W+2)'(nr - trial);
				root_q <= {root_q[NORM_W-2:0], 1'b1};
			end else begin
				rem_q <= nr[NORM_W+1:0];
				root_q <= {root_q[NORM_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule
`default_nettype wire

// File: hdl/vawn_datapath.sv
// Datapath: product pipeline, accumulators, norm, divide, CORDIC and result register.
// Depends on vawn_pkg and vawn_sqrt.
`default_nettype none
module vawn_datapath import vawn_pkg::*; #(
	parameter int MAX_LEN = DEF_MAX_LEN
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic signed [15:0] elem_a,
	input  wire logic signed [15:0] elem_b,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             angle,
	output logic [NORM_W-1:0]       norm_a,
	output logic [NORM_W-1:0]       norm_b,
	output logic [1:0]              status
);
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic               room;
	logic signed [31:0] p_dot_s1;
	logic [30:0]        p_a_s1;
	logic [30:0]        p_b_s1;
	logic               v_s1;
	logic [DOT_W-1:0]   dot_q;
	logic [SQ_W-1:0]    sqa_q;
	logic [SQ_W-1:0]    sqb_q;

	logic [RAD_W-1:0]   rad;
	logic [NORM_W-1:0]  root;
	logic               sq_done;
	logic [NORM_W-1:0]  na_q;
	logic [NORM_W-1:0]  nb_q;
	logic [NORM_W-1:0]  s_q;
	logic [DOT_W-1:0]   den_q;
	logic [DOT_W-1:0]   dmag;
	logic [DOT_W-1:0]   rem_q;
	logic [DOT_W:0]     r2;
	logic [13:0]        q_q;
	logic               sat_q;
	logic [14:0]        mag;
	logic               neg;
	logic [28:0]        msq_s1;

	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  at;
	logic                   y_pos;
	logic [21:0]            zc;
	logic [21:0]            zf;
	logic [22:0]            zr;
	logic                   zero_norm;
	logic                   out_valid_q;

	assign room = cnt_q < CNT_W'(MAX_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			dot_q <= '0;
			sqa_q <= '0;
			sqb_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.accept && room;
			if (cmd.clear) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				dot_q <= '0;
				sqa_q <= '0;
				sqb_q <= '0;
			end else begin
				if (cmd.accept) begin
					if (room) cnt_q <= cnt_q + 1'b1;
					else ovf_q <= 1'b1;
				end
				if (v_s1) begin
					dot_q <= dot_q + {{(DOT_W-32){p_dot_s1[31]}}, p_dot_s1};
					sqa_q <= sqa_q + {{(SQ_W-31){1'b0}}, p_a_s1};
					sqb_q <= sqb_q + {{(SQ_W-31){1'b0}}, p_b_s1};
				end
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_dot_s1 <= elem_a * elem_b;
			p_a_s1 <= 31'(32'(elem_a) * 32'(elem_a));
			p_b_s1 <= 31'(32'(elem_b) * 32'(elem_b));
		end
	end

	always_comb begin
		case (cmd.sq_sel)
			SQ_SEL_A: rad = {1'b0, sqa_q};
			SQ_SEL_B: rad = {1'b0, sqb_q};
			SQ_SEL_C: rad = {13'd0, RAD_ONE - msq_s1};
			default: rad = '0;
		endcase
	end

	vawn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (rad),
		.root     (root),
		.done     (sq_done)
	);

	assign dmag = dot_q[DOT_W-1] ? (~dot_q + 1'b1) : dot_q;
	assign r2 = {rem_q, 1'b0};
	assign mag = sat_q ? COS_ONE : {1'b0, q_q};
	assign neg = dot_q[DOT_W-1] && (mag != '0);

	assign xs = x_q >>> cmd.iter;
	assign ys = y_q >>> cmd.iter;
	assign at = Z_W'(atan_f(cmd.iter));
	assign y_pos = !y_q[XY_W-1] && (y_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.lat_na) na_q <= root;
		if (cmd.lat_nb) nb_q <= root;
		if (cmd.lat_s) s_q <= root;
		if (cmd.mul) den_q <= na_q * nb_q;
		if (cmd.div_init) begin
			rem_q <= dmag;
			q_q <= '0;
			sat_q <= dmag >= den_q;
		end else if (cmd.div_step) begin
			if (r2 >= {1'b0, den_q}) begin
				rem_q <= DOT_W'(r2 - {1'b0, den_q});
				q_q <= {q_q[12:0], 1'b1};
			end else begin
				rem_q <= r2[DOT_W-1:0];
				q_q <= {q_q[12:0], 1'b0};
			end
		end
		if (cmd.sq_mag) msq_s1 <= 29'({15'd0, mag} * {15'd0, mag});
		if (cmd.cor_init) begin
			x_q <= XY_W'(mag) <<< 16;
			y_q <= XY_W'(s_q) <<< 16;
			z_q <= '0;
		end else if (cmd.cor_step) begin
			if (y_pos) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign zero_norm = (na_q == '0) || (nb_q == '0);

	always_comb begin
		if (z_q[Z_W-1]) zc = '0;
		else if (z_q[21:0] > Z_HALF_PI) zc = Z_HALF_PI;
		else zc = z_q[21:0];
		zf = neg ? (Z_PI - zc) : zc;
		zr = {1'b0, zf} + 23'd32;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			angle <= zero_norm ? 16'd0 : zr[21:6];
			norm_a <= na_q;
			norm_b <= nb_q;
			status <= ovf_q ? ST_LONG : (zero_norm ? ST_ZERO : ST_OK);
		end
	end

	assign out_valid = out_valid_q;
	assign sts.sq_done = sq_done;
	assign sts.zero_norm = zero_norm;
	assign sts.out_free = !out_valid_q || !out_stall;
endmodule
`default_nettype wire

// File: hdl/vawn_ctrl.sv
// Controller state machine sequencing accumulation and the final evaluation.
// Depends on vawn_pkg.
`default_nettype none
module vawn_ctrl import vawn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic last_pair,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [14:0] {
		S_ACC    = 15'b000000000000001,
		S_DRAIN  = 15'b000000000000010,
		S_SQA_ST = 15'b000000000000100,
		S_SQA_WT = 15'b000000000001000,
		S_SQB_ST = 15'b000000000010000,
		S_SQB_WT = 15'b000000000100000,
		S_MUL    = 15'b000000001000000,
		S_CHK    = 15'b000000010000000,
		S_DIV    = 15'b000000100000000,
		S_MSQ    = 15'b000001000000000,
		S_SQC_ST = 15'b000010000000000,
		S_SQC_WT = 15'b000100000000000,
		S_CINIT  = 15'b001000000000000,
		S_COR    = 15'b010000000000000,
		S_FIN    = 15'b100000000000000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [3:0] cnt_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.iter = cnt_q;
		cmd.sq_sel = SQ_SEL_A;
		case (state_q)
			S_ACC: begin
				cmd.accept = in_valid;
				if (in_valid && last_pair) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_SQA_ST;
			S_SQA_ST: begin
				cmd.sq_start = 1'b1;
				state_d = S_SQA_WT;
			end
			S_SQA_WT: begin
				cmd.lat_na = sts.sq_done;
				if (sts.sq_done) state_d = S_SQB_ST;
			end
			S_SQB_ST: begin
				cmd.sq_sel = SQ_SEL_B;
				cmd.sq_start = 1'b1;
				state_d = S_SQB_WT;
			end
			S_SQB_WT: begin
				cmd.lat_nb = sts.sq_done;
				if (sts.sq_done) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.div_init = 1'b1;
				state_d = sts.zero_norm ? S_FIN : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) state_d = S_MSQ;
			end
			S_MSQ: begin
				cmd.sq_mag = 1'b1;
				state_d = S_SQC_ST;
			end
			S_SQC_ST: begin
				cmd.sq_sel = SQ_SEL_C;
				cmd.sq_start = 1'b1;
				state_d = S_SQC_WT;
			end
			S_SQC_WT: begin
				cmd.sq_sel = SQ_SEL_C;
				cmd.lat_s = sts.sq_done;
				if (sts.sq_done) state_d = S_CINIT;
			end
			S_CINIT: begin
				cmd.cor_init = 1'b1;
				state_d = S_COR;
			end
			S_COR: begin
				cmd.cor_step = 1'b1;
				if (cnt_q == COR_LAST) state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear = 1'b1;
					state_d = S_ACC;
				end
			end
			default: state_d = S_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else if (state_q == S_DIV || state_q == S_COR) cnt_q <= cnt_q + 4'd1;
		end
	end

	assign in_stall = (state_q != S_ACC);
endmodule
`default_nettype wire

// File: hdl/vector_angle_with_norms.sv
// Angle between two vectors from dot product and norms: top level.
// Depends on vawn_pkg, vawn_ctrl, vawn_datapath and the assertion macro header.
//
// Element pairs (signed Q8.8) are taken one per cycle while in_stall is low and
// accumulated; the pair marked last_pair closes the vectors. Evaluation then
// runs with in_stall high, waiting also while a previous result still sits
// stalled in the output register at the end: two 21-iteration bit-serial square
// roots for the norms, a restoring divide to a 14-bit quotient for the cosine,
// a third square root for the sine and 16 CORDIC iterations, all roots through
// one shared root unit. A result waits in the output register while the next
// vector streams in. Pairs past MAX_LEN are dropped and reported with status 2;
// a zero norm gives angle 0 and, unless pairs were dropped, status 1.
`default_nettype none
`include "vector_angle_with_norms_macros.svh"
module vector_angle_with_norms import vawn_pkg::*; #(
	parameter int MAX_LEN = DEF_MAX_LEN
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] elem_a,
	input  wire logic signed [15:0] elem_b,
	input  wire logic               last_pair,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             angle,
	output logic [NORM_W-1:0]       norm_a,
	output logic [NORM_W-1:0]       norm_b,
	output logic [1:0]              status
);
	cmd_t cmd;
	sts_t sts;

	vawn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_pair (last_pair),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vawn_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.elem_a    (elem_a),
		.elem_b    (elem_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.angle     (angle),
		.norm_a    (norm_a),
		.norm_b    (norm_b),
		.status    (status)
	);

	`VAWN_ASSERT_NXT(a_last_stalls, clk, arst_n, in_valid && !in_stall && last_pair, in_stall)
	`VAWN_ASSERT_IMP(a_angle_range, clk, arst_n, out_valid, angle <= 16'd51472)
	`VAWN_ASSERT_IMP(a_zero_angle, clk, arst_n, out_valid && status == ST_ZERO, angle == 16'd0)
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for vector_angle_with_norms: streams element pairs and predicts
// the norms, angle and status of each vector, then checks every result transaction.
// Depends on vawn_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb_top;
	import vawn_pkg::*;

	localparam int MAX_PAIRS = DEF_MAX_LEN;
	localparam int LIMIT_CYCLES = 600000;
	localparam int EVAL_CYCLES = 200;

	typedef struct {
		logic [15:0]       angle;
		logic [NORM_W-1:0] na;
		logic [NORM_W-1:0] nb;
		logic [1:0]        st;
	} vec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] elem_a = '0;
	logic signed [15:0] elem_b = '0;
	logic last_pair = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] angle;
	logic [NORM_W-1:0] norm_a;
	logic [NORM_W-1:0] norm_b;
	logic [1:0] status;

	vec_result_t results_due[$];
	longint dot_sum;
	longint sq_sum_a;
	longint sq_sum_b;
	int pairs_taken;
	bit dropped;
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	int sent = 0;

	vector_angle_with_norms dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.elem_a(elem_a), .elem_b(elem_b), .last_pair(last_pair),
		.out_valid(out_valid), .out_stall(out_stall),
		.angle(angle), .norm_a(norm_a), .norm_b(norm_b), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] acos_of_cos(input longint c);
		longint mag;
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		mag = (c < 0) ? -c : c;
		x = mag * 65536;
		y = longint'(floor_sqrt(longint'(RAD_ONE) - mag * mag)) * 65536;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z += longint'(atan_f(4'(i)));
			end else begin
				x = x - ys;
				y = y + xs;
				z -= longint'(atan_f(4'(i)));
			end
		end
		if (z < 0)
			z = 0;
		if (z > longint'(Z_HALF_PI))
			z = longint'(Z_HALF_PI);
		if (c < 0)
			z = longint'(Z_PI) - z;
		return 16'((z + 32) >> 6);
	endfunction

	task automatic accumulate_pair(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic last);
		vec_result_t r;
		longint dmag;
		longint den;
		longint cm;
		if (pairs_taken < MAX_PAIRS) begin
			dot_sum += longint'(a) * longint'(b);
			sq_sum_a += longint'(a) * longint'(a);
			sq_sum_b += longint'(b) * longint'(b);
			pairs_taken++;
		end else begin
			dropped = 1'b1;
		end
		if (!last)
			return;
		r.na = NORM_W'(floor_sqrt(sq_sum_a));
		r.nb = NORM_W'(floor_sqrt(sq_sum_b));
		r.angle = '0;
		if (r.na == 0 || r.nb == 0) begin
			r.st = ST_ZERO;
		end else begin
			dmag = (dot_sum < 0) ? -dot_sum : dot_sum;
			den = longint'(r.na) * longint'(r.nb);
			cm = ((dmag << 14) >= den * 16384) ? 16384 : (dmag << 14) / den;
			r.angle = acos_of_cos((dot_sum < 0) ? -cm : cm);
			r.st = ST_OK;
		end
		if (dropped)
			r.st = ST_LONG;
		results_due.push_back(r);
		dot_sum = 0;
		sq_sum_a = 0;
		sq_sum_b = 0;
		pairs_taken = 0;
		dropped = 1'b0;
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic last);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		elem_a = a;
		elem_b = b;
		last_pair = last;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		accumulate_pair(a, b, last);
		sent++;
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid = 1'b0;
		wait (results_due.size() == 0);
		repeat (EVAL_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_elem(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 1023)) - 512);
			2: return 16'sd0;
			default: return 16'($signed($urandom_range(0, 65535)) >>> $urandom_range(0, 12));
		endcase
	endfunction

	task automatic test_extremes;
		send_pair(16'sh7fff, 16'sh7fff, 1'b0);
		send_pair(-16'sh8000, -16'sh8000, 1'b1);
		send_pair(-16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sh7fff, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sh7fff, 1'b1);
		send_pair(16'sd1, 16'sd1, 1'b1);
		send_pair(16'sd1, -16'sd1, 1'b1);
		send_pair(16'sd256, 16'sd300, 1'b0);
		send_pair(-16'sd77, 16'sd5, 1'b1);
		send_pair(16'sh5555, -16'sh2aab, 1'b1);
	endtask

	task automatic test_zero_norm;
		send_pair(16'sd0, 16'sd5, 1'b1);
		send_pair(16'sd9, 16'sd0, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sd0, 1'b1);
	endtask

	task automatic test_too_long;
		for (int i = 0; i < MAX_PAIRS + 6; i++)
			send_pair(pick_elem(1), pick_elem(1), i == MAX_PAIRS + 5);
		for (int i = 0; i < 4; i++)
			send_pair(16'sd0, 16'sd0, 1'b0);
		send_pair(16'sd100, 16'sd100, 1'b1);
	endtask

	task automatic test_random_vectors(input int items);
		int len;
		int mode;
		int rel;
		logic signed [15:0] a;
		logic signed [15:0] b;
		while (items > 0) begin
			len = $urandom_range(1, 12);
			mode = $urandom_range(0, 3);
			rel = $urandom_range(0, 5);
			for (int i = 0; i < len; i++) begin
				quiet = items < 80;
				a = pick_elem(($urandom_range(0, 15) == 0) ? 2 : mode);
				case (rel)
					0: b = a;
					1: b = -a;
					default: b = pick_elem(($urandom_range(0, 15) == 0) ? 2 : mode);
				endcase
				send_pair(a, b, i == len - 1);
				items--;
			end
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		vec_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report("unexpected result", angle, -1);
			end else begin
				w = results_due.pop_front();
				if (angle !== w.angle)
					report("angle", angle, w.angle);
				if (norm_a !== w.na)
					report("norm_a", norm_a, w.na);
				if (norm_b !== w.nb)
					report("norm_b", norm_b, w.nb);
				if (status !== w.st)
					report("status", status, w.st);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		dot_sum = 0;
		sq_sum_a = 0;
		sq_sum_b = 0;
		pairs_taken = 0;
		dropped = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_zero_norm();
		drain();
		test_too_long();
		drain();
		test_random_vectors(650);
		@(negedge clk);
		in_valid = 1'b0;
		wait (results_due.size() == 0);
		repeat (EVAL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hdl
hdl/vawn_pkg.sv
hdl/vawn_sqrt.sv
hdl/vawn_datapath.sv
hdl/vawn_ctrl.sv
hdl/vector_angle_with_norms.sv
bench/tb_top.sv
